@@ src/rxrb_pkg.sv @@
// Shared types and codes for the receive ring buffer line reader.
// No dependencies; rxrb_ctrl, the top level and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package rxrb_pkg;

	localparam int DEPTH_DEF = 64;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		OP_STORE     = 2'd0,
		OP_READ_ONE  = 2'd1,
		OP_READ_MANY = 2'd2,
		OP_READ_LINE = 2'd3
	} op_t;

	localparam logic [2:0] STAT_STORED  = 3'd0;
	localparam logic [2:0] STAT_DROPPED = 3'd1;
	localparam logic [2:0] STAT_DATA    = 3'd2;
	localparam logic [2:0] STAT_EMPTY   = 3'd3;
	localparam logic [2:0] STAT_LINEEND = 3'd4;
	localparam logic [2:0] STAT_NOLINE  = 3'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_LINE
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] rx_byte;
		logic [6:0] request_len;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] status;
		logic [5:0] fill_level;
		logic       last;
	} rx_result_t;

	typedef struct packed {
		logic       valid;
		rx_result_t beat;
	} emit_t;

endpackage

`default_nettype wire

@@ src/rxrb_mem.sv @@
// Byte store of the ring buffer: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module rxrb_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/rxrb_ctrl.sv @@
// Pointer and sequencing logic of the ring buffer: stores, reads and line scans.
// Depends on rxrb_pkg; drives the byte store in rxrb_mem.
`timescale 1ns / 1ps
`default_nettype none

module rxrb_ctrl #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rxrb_pkg::rx_item_t item,
	output logic                   busy,
	output rxrb_pkg::emit_t        emit,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [7:0]             mem_wdata,
	output logic [AW-1:0]          mem_raddr,
	input  wire logic [7:0]        mem_rdata
);

	import rxrb_pkg::*;

	state_t state_q, state_d;

	logic [AW-1:0] wp_q, rp_q, iptr_q, end_q, pos_s1;
	logic          pend_s1;
	logic [6:0]    len_q, cnt_q, ocnt_q, icnt_q;

	logic          full, empty, accept, issue;
	logic [6:0]    eff_len;
	logic          rd_last, lf_hit, scan_miss, line_done, line_data;

	function automatic logic [AW-1:0] nxt_f(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

	function automatic logic [5:0] lvl_f(input logic [AW-1:0] w, input logic [AW-1:0] r);
		logic [6:0] wx, rx, dx, diff;
		wx = 7'(w);
		rx = 7'(r);
		dx = 7'(DEPTH);
		if (wx >= rx) diff = wx - rx;
		else diff = wx + dx - rx;
		return diff[5:0];
	endfunction

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign full    = (nxt_f(wp_q) == rp_q);
	assign empty   = (wp_q == rp_q);
	assign eff_len = (item.op == OP_READ_ONE) ? 7'd1 : item.request_len;

	// Data-stage conditions; pend_s1 marks a store read whose byte is on mem_rdata.
	assign rd_last   = pend_s1 && ((pos_s1 == wp_q) || (ocnt_q + 7'd1 == len_q));
	assign lf_hit    = pend_s1 && (mem_rdata == CHAR_LF);
	assign scan_miss = !pend_s1 && (iptr_q == wp_q);
	assign line_done = (ocnt_q == cnt_q);
	assign line_data = !line_done && pend_s1 && (mem_rdata != CHAR_CR);

	assign mem_waddr = wp_q;
	assign mem_wdata = item.rx_byte;
	assign mem_raddr = iptr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.op)
						OP_READ_ONE, OP_READ_MANY: begin
							if (!empty && eff_len != 7'd0) state_d = S_READ;
						end
						OP_READ_LINE: begin
							if (item.request_len >= 7'd2) state_d = S_SCAN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ: begin
				if (rd_last) state_d = S_IDLE;
			end
			S_SCAN: begin
				if (lf_hit) state_d = S_LINE;
				else if (scan_miss) state_d = S_IDLE;
			end
			S_LINE: begin
				if (line_done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		emit   = '0;
		mem_we = 1'b0;
		issue  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					emit.beat.last = 1'b1;
					case (item.op)
						OP_STORE: begin
							emit.valid = 1'b1;
							if (!full) begin
								mem_we                = 1'b1;
								emit.beat.status     = STAT_STORED;
								emit.beat.fill_level = lvl_f(nxt_f(wp_q), rp_q);
							end else begin
								emit.beat.status     = STAT_DROPPED;
								emit.beat.fill_level = lvl_f(wp_q, rp_q);
							end
						end
						OP_READ_ONE, OP_READ_MANY: begin
							if (empty || eff_len == 7'd0) begin
								emit.valid           = 1'b1;
								emit.beat.status     = STAT_EMPTY;
								emit.beat.fill_level = lvl_f(wp_q, rp_q);
							end
						end
						OP_READ_LINE: begin
							if (item.request_len < 7'd2) begin
								emit.valid           = 1'b1;
								emit.beat.status     = STAT_NOLINE;
								emit.beat.fill_level = lvl_f(wp_q, rp_q);
							end
						end
						default: emit.valid = 1'b0;
					endcase
				end
			end
			S_READ: begin
				issue = (iptr_q != wp_q) && (icnt_q < len_q);
				if (pend_s1) begin
					emit.valid           = 1'b1;
					emit.beat.data       = mem_rdata;
					emit.beat.status     = STAT_DATA;
					emit.beat.fill_level = lvl_f(wp_q, pos_s1);
					emit.beat.last       = rd_last;
				end
			end
			S_SCAN: begin
				issue = (iptr_q != wp_q) && !lf_hit;
				if (scan_miss) begin
					emit.valid           = 1'b1;
					emit.beat.status     = STAT_NOLINE;
					emit.beat.fill_level = lvl_f(wp_q, rp_q);
					emit.beat.last       = 1'b1;
				end
			end
			S_LINE: begin
				issue = (iptr_q != end_q) && !line_done;
				if (line_done) begin
					emit.valid           = 1'b1;
					emit.beat.status     = STAT_LINEEND;
					emit.beat.fill_level = lvl_f(wp_q, end_q);
					emit.beat.last       = 1'b1;
				end else if (line_data) begin
					emit.valid           = 1'b1;
					emit.beat.data       = mem_rdata;
					emit.beat.status     = STAT_DATA;
					emit.beat.fill_level = lvl_f(wp_q, end_q);
				end
			end
			default: emit = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (mem_we) wp_q <= nxt_f(wp_q);
			if (state_q == S_READ && pend_s1) rp_q <= pos_s1;
			if (state_q == S_LINE && line_done) rp_q <= end_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			iptr_q <= nxt_f(iptr_q);
			pos_s1 <= nxt_f(iptr_q);
			icnt_q <= icnt_q + 7'd1;
		end
		case (state_q)
			S_IDLE: begin
				iptr_q <= rp_q;
				len_q  <= eff_len;
				cnt_q  <= '0;
				ocnt_q <= '0;
				icnt_q <= '0;
			end
			S_READ: begin
				if (pend_s1) ocnt_q <= ocnt_q + 7'd1;
			end
			S_SCAN: begin
				// The kept count stops at the line buffer size less its terminator.
				if (lf_hit) begin
					end_q  <= pos_s1;
					iptr_q <= rp_q;
				end else if (pend_s1 && mem_rdata != CHAR_CR && cnt_q < len_q - 7'd1) begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
			S_LINE: begin
				if (line_data) ocnt_q <= ocnt_q + 7'd1;
			end
			default: len_q <= len_q;
		endcase
	end

endmodule

`default_nettype wire

@@ src/rx_ring_buffer_line_reader.sv @@
// Top level of the receive ring buffer line reader: store, controller, result register.
// Depends on rxrb_pkg, rxrb_mem and rxrb_ctrl.
//
//   channel   handshake      payload                 direction
//   item      start / busy   item   (rx_item_t)      in
//   result    strobe         result (rx_result_t)    out
//
// A store, or any read that ends at once (empty, limit below two), finishes in the idle state.
// A read of n bytes issues one store read per byte through the byte store's registered
// read port. A line read scans the held bytes up to the first LF, then reads the line
// again to deliver its characters, skipping CR. Results are registered and leave in the
// cycle after they form.
// Reset clears both pointers, so the buffer starts empty; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module rx_ring_buffer_line_reader #(
	parameter int DEPTH = rxrb_pkg::DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire rxrb_pkg::rx_item_t  item,
	output logic                     busy,
	output logic                     strobe,
	output rxrb_pkg::rx_result_t     result
);

	import rxrb_pkg::*;

	localparam int AW = $clog2(DEPTH);

	emit_t         emit;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	rxrb_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.emit      (emit),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	rxrb_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Each beat is registered here and shown for exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			result <= emit.beat;
		end
	end

endmodule

`default_nettype wire

@@ tb/rx_ring_buffer_line_reader_test.sv @@
// Testbench for the receive ring buffer line reader: directed table, then random command mix.
// Depends on rxrb_pkg and rx_ring_buffer_line_reader; every result beat is checked in order.
`timescale 1ns / 1ps

module rx_ring_buffer_line_reader_test;

	import rxrb_pkg::*;

	localparam int  RING_SLOTS  = 64;
	localparam int  RANDOM_CMDS = 300;
	localparam int  CYCLE_LIMIT = 500000;
	localparam int  DRAIN_WAIT  = 200;
	localparam bit  TYPED       = 1'b1;
	localparam bit  PREDICTED   = 1'b0;

	typedef struct {
		rx_item_t   cmd;
		bit         typed;
		rx_result_t beat;
	} step_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	rx_item_t   item;
	logic       busy;
	logic       strobe;
	rx_result_t result;

	// Shadow copy of the ring and its pointers; 6-bit pointers wrap on their own.
	logic [7:0] shadow_bytes [RING_SLOTS];
	logic [5:0] shadow_wr;
	logic [5:0] shadow_rd;

	rx_result_t new_beats[$];
	rx_result_t awaited_results[$];
	step_row_t  plan[$];

	int  error_count;
	int  cycle_count;
	int  issued;
	bit  calm;

	rx_ring_buffer_line_reader dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		error_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic void add_beat(input logic [7:0] data, input logic [2:0] status);
		rx_result_t b;
		b.data       = data;
		b.status     = status;
		b.fill_level = shadow_wr - shadow_rd;
		b.last       = 1'b0;
		new_beats.push_back(b);
	endfunction

	// Works out the beats one command causes and advances the shadow ring.
	function automatic void predict_command(input rx_item_t c);
		logic [5:0] nxt;
		logic [5:0] pos;
		logic [7:0] b;
		logic [7:0] kept[$];
		int         cnt;
		bit         found;
		new_beats.delete();
		case (c.op)
			OP_STORE: begin
				nxt = shadow_wr + 6'd1;
				if (nxt != shadow_rd) begin
					shadow_bytes[shadow_wr] = c.rx_byte;
					shadow_wr = nxt;
					add_beat(8'h00, STAT_STORED);
				end else begin
					add_beat(8'h00, STAT_DROPPED);
				end
			end
			OP_READ_ONE: begin
				if (shadow_rd == shadow_wr) begin
					add_beat(8'h00, STAT_EMPTY);
				end else begin
					b = shadow_bytes[shadow_rd];
					shadow_rd = shadow_rd + 6'd1;
					add_beat(b, STAT_DATA);
				end
			end
			OP_READ_MANY: begin
				cnt = 0;
				while (cnt < int'(c.request_len) && shadow_rd != shadow_wr) begin
					b = shadow_bytes[shadow_rd];
					shadow_rd = shadow_rd + 6'd1;
					add_beat(b, STAT_DATA);
					cnt++;
				end
				if (new_beats.size() == 0)
					add_beat(8'h00, STAT_EMPTY);
			end
			default: begin
				found = 1'b0;
				pos = shadow_rd;
				if (c.request_len >= 7'd2) begin
					while (pos != shadow_wr && !found) begin
						b = shadow_bytes[pos];
						pos = pos + 6'd1;
						if (b == CHAR_LF)
							found = 1'b1;
						else if (b != CHAR_CR && kept.size() < int'(c.request_len) - 1)
							kept.push_back(b);
					end
				end
				if (found) begin
					// The whole line leaves the ring before its first beat goes out.
					shadow_rd = pos;
					foreach (kept[i])
						add_beat(kept[i], STAT_DATA);
					add_beat(8'h00, STAT_LINEEND);
				end else begin
					add_beat(8'h00, STAT_NOLINE);
				end
			end
		endcase
		new_beats[new_beats.size() - 1].last = 1'b1;
	endfunction

	// Called at a falling edge; returns at the falling edge after the command is taken.
	task automatic send_command(input rx_item_t c, input bit typed, input rx_result_t typed_beat);
		while (!calm && $urandom_range(0, 99) < 30) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		item  = c;
		do @(posedge clk); while (busy);
		predict_command(c);
		if (typed)
			awaited_results.push_back(typed_beat);
		else
			foreach (new_beats[i])
				awaited_results.push_back(new_beats[i]);
		issued++;
		@(negedge clk);
	endtask

	task automatic issue(input op_t op, input logic [7:0] rx_b, input logic [6:0] len);
		rx_item_t c;
		c.op          = op;
		c.rx_byte     = rx_b;
		c.request_len = len;
		send_command(c, PREDICTED, '0);
	endtask

	task automatic add_row(input op_t op, input logic [7:0] rx_b, input logic [6:0] len,
			input bit typed, input logic [2:0] status, input logic [7:0] data,
			input logic [5:0] fill);
		step_row_t r;
		r.cmd.op          = op;
		r.cmd.rx_byte     = rx_b;
		r.cmd.request_len = len;
		r.typed           = typed;
		r.beat.data       = data;
		r.beat.status     = status;
		r.beat.fill_level = fill;
		r.beat.last       = 1'b1;
		plan.push_back(r);
	endtask

	// Any byte but LF, with CR now and then so the line scan has something to skip.
	function automatic logic [7:0] line_char();
		logic [7:0] b;
		if ($urandom_range(0, 7) == 0)
			return CHAR_CR;
		do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
		return b;
	endfunction

	function automatic logic [6:0] line_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 7'($urandom_range(0, 1));
		else if (r < 20)
			return 7'($urandom_range(65, 127));
		else if (r < 30)
			return 7'd64;
		return 7'($urandom_range(2, 64));
	endfunction

	task automatic fill_burst();
		int extra;
		extra = $urandom_range(1, 3);
		while (shadow_wr + 6'd1 != shadow_rd)
			issue(OP_STORE,
				($urandom_range(0, 15) == 0) ? CHAR_LF : 8'($urandom_range(0, 255)), '0);
		repeat (extra)
			issue(OP_STORE, 8'($urandom_range(0, 255)), '0);
		issue(OP_READ_LINE, 8'(line_limit()), line_limit());
		issue(OP_READ_MANY, 8'h00, 7'd64);
	endtask

	task automatic line_sequence();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 62) : $urandom_range(0, 12);
		repeat (n)
			issue(OP_STORE, line_char(), 7'($urandom_range(0, 127)));
		if ($urandom_range(0, 9) != 0)
			issue(OP_STORE, CHAR_LF, 7'($urandom_range(0, 127)));
		issue(OP_READ_LINE, 8'($urandom_range(0, 255)), line_limit());
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (awaited_results.size() == 0) begin
				flag_error($sformatf("unexpected beat data %h status %0d fill %0d last %b",
					result.data, result.status, result.fill_level, result.last));
			end else begin
				rx_result_t want;
				want = awaited_results.pop_front();
				if (result.data !== want.data || result.status !== want.status ||
						result.fill_level !== want.fill_level || result.last !== want.last)
					flag_error($sformatf(
						"beat data %h/%h status %0d/%0d fill %0d/%0d last %b/%b (got/want)",
						result.data, want.data, result.status, want.status,
						result.fill_level, want.fill_level, result.last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int r;
		rx_item_t c;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		error_count = 0;
		cycle_count = 0;
		issued = 0;
		calm = 1'b0;
		shadow_wr = '0;
		shadow_rd = '0;
		foreach (shadow_bytes[i])
			shadow_bytes[i] = 8'h00;

		// Empty ring right after reset, byte extremes, line limit below two and no LF.
		add_row(OP_READ_ONE,  8'h00,   7'd0,   TYPED,     STAT_EMPTY,   8'h00, 6'd0);
		add_row(OP_READ_MANY, 8'h00,   7'd5,   TYPED,     STAT_EMPTY,   8'h00, 6'd0);
		add_row(OP_READ_MANY, 8'hFF,   7'd127, TYPED,     STAT_EMPTY,   8'h00, 6'd0);
		add_row(OP_READ_LINE, 8'h00,   7'd10,  TYPED,     STAT_NOLINE,  8'h00, 6'd0);
		add_row(OP_STORE,     8'h00,   7'd0,   TYPED,     STAT_STORED,  8'h00, 6'd1);
		add_row(OP_STORE,     8'hFF,   7'd127, TYPED,     STAT_STORED,  8'h00, 6'd2);
		add_row(OP_STORE,     CHAR_CR, 7'd0,   TYPED,     STAT_STORED,  8'h00, 6'd3);
		add_row(OP_STORE,     8'h41,   7'd0,   TYPED,     STAT_STORED,  8'h00, 6'd4);
		add_row(OP_STORE,     CHAR_LF, 7'd0,   TYPED,     STAT_STORED,  8'h00, 6'd5);
		add_row(OP_READ_LINE, 8'h00,   7'd1,   TYPED,     STAT_NOLINE,  8'h00, 6'd5);
		add_row(OP_READ_LINE, 8'h00,   7'd0,   TYPED,     STAT_NOLINE,  8'h00, 6'd5);
		add_row(OP_READ_MANY, 8'h00,   7'd0,   TYPED,     STAT_EMPTY,   8'h00, 6'd5);
		add_row(OP_READ_LINE, 8'h00,   7'd3,   PREDICTED, STAT_LINEEND, 8'h00, 6'd0);
		add_row(OP_STORE,     8'h5A,   7'd0,   TYPED,     STAT_STORED,  8'h00, 6'd1);
		add_row(OP_READ_ONE,  8'h00,   7'd0,   TYPED,     STAT_DATA,    8'h5A, 6'd0);
		add_row(OP_STORE,     8'h78,   7'd0,   PREDICTED, STAT_STORED,  8'h00, 6'd1);
		add_row(OP_STORE,     CHAR_CR, 7'd0,   PREDICTED, STAT_STORED,  8'h00, 6'd2);
		add_row(OP_STORE,     8'h79,   7'd0,   PREDICTED, STAT_STORED,  8'h00, 6'd3);
		add_row(OP_READ_LINE, 8'h00,   7'd64,  TYPED,     STAT_NOLINE,  8'h00, 6'd3);
		add_row(OP_STORE,     CHAR_LF, 7'd0,   PREDICTED, STAT_STORED,  8'h00, 6'd4);
		add_row(OP_READ_LINE, 8'h00,   7'd127, PREDICTED, STAT_LINEEND, 8'h00, 6'd0);
		add_row(OP_STORE,     8'h80,   7'd0,   PREDICTED, STAT_STORED,  8'h00, 6'd1);
		add_row(OP_STORE,     CHAR_LF, 7'd0,   PREDICTED, STAT_STORED,  8'h00, 6'd2);
		add_row(OP_READ_LINE, 8'h00,   7'd2,   PREDICTED, STAT_LINEEND, 8'h00, 6'd0);
		add_row(OP_READ_MANY, 8'h00,   7'd64,  TYPED,     STAT_EMPTY,   8'h00, 6'd0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_command(plan[i].cmd, plan[i].typed, plan[i].beat);

		// Random part: whole lines most often, a few full-ring bursts, plain reads and noise.
		fill_burst();
		while (issued < RANDOM_CMDS + plan.size()) begin
			calm = (issued >= 150 && issued < 210);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				line_sequence();
			end else if (r < 50) begin
				fill_burst();
			end else if (r < 75) begin
				if ($urandom_range(0, 1) == 0)
					issue(OP_READ_ONE, 8'($urandom_range(0, 255)),
						7'($urandom_range(0, 127)));
				else
					issue(OP_READ_MANY, 8'($urandom_range(0, 255)),
						7'(($urandom_range(0, 9) == 0) ? $urandom_range(65, 127)
							: $urandom_range(0, 64)));
			end else begin
				c.op          = op_t'($urandom_range(0, 3));
				c.rx_byte     = 8'($urandom_range(0, 255));
				c.request_len = 7'($urandom_range(0, 127));
				send_command(c, PREDICTED, '0);
			end
		end
		start = 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
